// ----- hw/rtl/line_column_cutter_macros.svh -----
// Assertion macros for the line column cutter.
`ifndef LINE_COLUMN_CUTTER_MACROS_SVH
`define LINE_COLUMN_CUTTER_MACROS_SVH
`ifndef SYNTHESIS
`define LCC_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
`define LCC_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`else
`define LCC_ASSERT_IMP(label, clk, rst, lhs, rhs)
`define LCC_ASSERT_NEXT(label, clk, rst, lhs, rhs)
`endif
`endif

// ----- hw/rtl/lcc_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Line column cutter package
// Shared types and constants.
// ---------------------------------------------------------------------------
package lcc_pkg;
   localparam int NUM_RANGES_DEFAULT = 4;
   localparam int POSITION_BITS_DEFAULT = 16;
   localparam int FIELD_BUFFER_DEPTH_DEFAULT = 62;
   localparam logic [7:0] NEWLINE = 8'd10;
   localparam logic [7:0] DELIM_RESET = 8'd9;

   localparam logic [2:0] CSR_UNIT = 3'd0;
   localparam logic [2:0] CSR_DELIM = 3'd1;
   localparam logic [2:0] CSR_SUPPRESS = 3'd2;
   localparam logic [2:0] CSR_RANGE0 = 3'd3;

   localparam logic [1:0] UNIT_BYTES = 2'd0;
   localparam logic [1:0] UNIT_CHARS = 2'd1;
   localparam logic [1:0] UNIT_FIELDS = 2'd2;

   typedef struct packed {
      logic [7:0] in_byte;
      logic end_of_input;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic last_of_run;
      logic field_truncated;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TAIL,
      ST_REPLAY,
      ST_DRAIN,
      ST_CLOSE,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic wr;
      logic [5:0] addr;
      logic [7:0] data;
      logic rd;
      logic [5:0] raddr;
   } mem_ctl_type;

   function automatic logic [2:0] seq_need(input logic [7:0] lead);
      if (lead >= 8'hC2 && lead <= 8'hDF) return 3'd2;
      if (lead >= 8'hE0 && lead <= 8'hEF) return 3'd3;
      if (lead >= 8'hF0 && lead <= 8'hF4) return 3'd4;
      return 3'd0;
   endfunction

   function automatic logic cont_ok(input logic [7:0] lead, input logic [2:0] idx,
                                    input logic [7:0] c);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = 8'h80;
      hi = 8'hBF;
      if (idx == 3'd1) begin
         if (lead == 8'hE0) lo = 8'hA0;
         else if (lead == 8'hED) hi = 8'h9F;
         else if (lead == 8'hF0) lo = 8'h90;
         else if (lead == 8'hF4) hi = 8'h8F;
      end
      return (c >= lo) && (c <= hi);
   endfunction
endpackage

// ----- hw/rtl/lcc_field_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Line column cutter first field store
// Synchronous memory with one write port and one registered read port.
// ---------------------------------------------------------------------------
module lcc_field_ram import lcc_pkg::*; #(
   parameter int DEPTH = FIELD_BUFFER_DEPTH_DEFAULT
) (
   input logic clock,
   input mem_ctl_type ctl,
   output logic [7:0] rdata
);
   logic [7:0] mem [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr) mem[ctl.addr[$clog2(DEPTH)-1:0]] <= ctl.data;
      if (ctl.rd) rdata_ff <= mem[ctl.raddr[$clog2(DEPTH)-1:0]];
   end

   assign rdata = rdata_ff;
endmodule

// ----- hw/rtl/line_column_cutter.sv -----
`timescale 1ns / 1ps
// Line column cutter: in character mode a selected UTF-8 character is sent
// byte by byte once its last byte arrives; a beat that breaks a held
// sequence, or ends a line while bytes are held, replays the held bytes first.
// In field mode the first field sits in a 62-entry (by default) synchronous
// memory; the first delimiter of a line whose selected first field is not
// empty, and the end of a passed undelimited line with a non-empty first
// field, drain it one byte per cycle while the output can take them. Bytes
// sent from the idle and tail states go straight into a one-entry output
// register; replayed and drained bytes pass through a one-entry staging
// register first. The request side stalls while a beat is being worked off
// or the output register is held. Write the unit register only while idle;
// doing so clears the line state.
// ---------------------------------------------------------------------------
// Line column cutter
// Per-line selection of bytes, UTF-8 characters or delimited fields.
// ---------------------------------------------------------------------------
`include "line_column_cutter_macros.svh"
module line_column_cutter import lcc_pkg::*; #(
   parameter int NUM_RANGES = NUM_RANGES_DEFAULT,
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT,
   parameter int FIELD_BUFFER_DEPTH = FIELD_BUFFER_DEPTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output rsp_type rsp_data,
   input logic csr_write,
   input logic [2:0] csr_index,
   input logic [31:0] csr_data
);
   localparam int NR = (NUM_RANGES < 4) ? NUM_RANGES : 4;
   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
   localparam logic [5:0] DEPTH6 = 6'(FIELD_BUFFER_DEPTH);

   logic [1:0] unit_ff;
   logic [7:0] delim_ff;
   logic supp_ff;
   logic [NR-1:0][31:0] range_ff;

   state_type state_ff, state_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [3:0][7:0] pend_ff, pend_in;
   logic [2:0] pcnt_ff, pcnt_in;
   logic [2:0] pidx_ff, pidx_in;
   logic [7:0] hold_ff, hold_in;
   logic hold_nl_ff, hold_nl_in;
   logic hold_end_ff, hold_end_in;
   logic [5:0] fcnt_ff, fcnt_in;
   logic [5:0] didx_ff, didx_in;
   logic dseen_ff, dseen_in;
   logic wrote_ff, wrote_in;
   logic ovf_ff, ovf_in;
   logic rv_ff, rv_in;
   rsp_type rd_ff, rd_in;
   logic stg_v_ff, stg_v_in;
   rsp_type stg_ff, stg_in;
   mem_ctl_type ctl;
   logic [7:0] ram_q;

   lcc_field_ram #(.DEPTH(FIELD_BUFFER_DEPTH)) u_ram (
      .clock(clock), .ctl(ctl), .rdata(ram_q)
   );

   function automatic logic chosen(input logic [POSITION_BITS-1:0] p,
                                   input logic [NR-1:0][31:0] r);
      logic hit;
      logic [31:0] pp;
      hit = 1'b0;
      pp = 32'(p);
      for (int k = 0; k < NR; k++) begin
         if (r[k][31:16] != 16'd0 && pp >= 32'(r[k][31:16]) &&
             (r[k][15:0] == 16'd0 || pp <= 32'(r[k][15:0]))) hit = 1'b1;
      end
      return hit;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff <= UNIT_BYTES;
         delim_ff <= DELIM_RESET;
         supp_ff <= 1'b0;
         range_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_UNIT: unit_ff <= csr_data[1:0];
            CSR_DELIM: delim_ff <= csr_data[7:0];
            CSR_SUPPRESS: supp_ff <= csr_data[0];
            default: begin
               for (int k = 0; k < NR; k++)
                  if (csr_index == CSR_RANGE0 + 3'(k)) range_ff[k] <= csr_data;
            end
         endcase
      end
   end

   logic [7:0] b;
   logic eoi, nl, ch, ch_nx, out_free, can_go, trunc_now;
   logic [POSITION_BITS-1:0] pos_nx;

   assign b = req_data.in_byte;
   assign eoi = req_data.end_of_input;
   assign nl = !eoi && (b == NEWLINE);
   assign pos_nx = (pos_ff != POS_MAX) ? pos_ff + POSITION_BITS'(1) : pos_ff;
   assign ch = chosen(pos_ff, range_ff);
   assign ch_nx = chosen(pos_nx, range_ff);
   assign out_free = !rv_ff || !rsp_stall;
   assign can_go = !stg_v_ff || out_free;
   assign trunc_now = (unit_ff == UNIT_FIELDS) && ovf_ff;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;

   logic put, dout, dlast, line_clr;
   logic [7:0] pb, db;

   always_comb begin
      state_in = state_ff;
      pos_in = pos_ff;
      pend_in = pend_ff;
      pcnt_in = pcnt_ff;
      pidx_in = pidx_ff;
      hold_in = hold_ff;
      hold_nl_in = hold_nl_ff;
      hold_end_in = hold_end_ff;
      fcnt_in = fcnt_ff;
      didx_in = didx_ff;
      dseen_in = dseen_ff;
      wrote_in = wrote_ff;
      ovf_in = ovf_ff;
      rv_in = rv_ff && rsp_stall;
      rd_in = rd_ff;
      stg_v_in = stg_v_ff;
      stg_in = stg_ff;
      ctl = '0;
      put = 1'b0;
      pb = 8'd0;
      dout = 1'b0;
      db = 8'd0;
      dlast = 1'b1;
      line_clr = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               case (unit_ff)
                  UNIT_FIELDS: begin
                     if (eoi || nl) begin
                        if (!dseen_ff && !supp_ff && fcnt_ff != 6'd0) begin
                           ctl.rd = 1'b1;
                           ctl.raddr = 6'd0;
                           didx_in = 6'd1;
                           hold_end_in = 1'b1;
                           hold_nl_in = nl;
                           state_in = ST_DRAIN;
                        end else begin
                           if (nl && (dseen_ff || !supp_ff)) begin
                              dout = 1'b1; db = NEWLINE;
                           end
                           line_clr = 1'b1;
                        end
                     end else if (b == delim_ff) begin
                        dseen_in = 1'b1;
                        if (!dseen_ff && ch && fcnt_ff != 6'd0) begin
                           wrote_in = 1'b1;
                           ctl.rd = 1'b1;
                           ctl.raddr = 6'd0;
                           didx_in = 6'd1;
                           hold_end_in = 1'b0;
                           state_in = ST_DRAIN;
                        end else begin
                           pos_in = pos_nx;
                           wrote_in = wrote_ff || (!dseen_ff && ch);
                           if (ch_nx) begin
                              if (wrote_in) begin
                                 dout = 1'b1; db = delim_ff;
                              end
                              wrote_in = 1'b1;
                           end
                        end
                     end else if (!dseen_ff) begin
                        if (fcnt_ff < DEPTH6) begin
                           ctl.wr = 1'b1;
                           ctl.addr = fcnt_ff;
                           ctl.data = b;
                           fcnt_in = fcnt_ff + 6'd1;
                        end else begin
                           ovf_in = 1'b1;
                        end
                     end else if (ch) begin
                        dout = 1'b1; db = b;
                     end
                  end
                  UNIT_CHARS: begin
                     if (eoi || nl) begin
                        if (pcnt_ff != 3'd0) begin
                           pidx_in = 3'd0;
                           hold_end_in = 1'b1;
                           hold_nl_in = nl;
                           state_in = ST_REPLAY;
                        end else begin
                           if (nl) begin
                              dout = 1'b1; db = NEWLINE;
                           end
                           line_clr = 1'b1;
                        end
                     end else if (pcnt_ff != 3'd0 && cont_ok(pend_ff[0], pcnt_ff, b)) begin
                        pend_in[pcnt_ff[1:0]] = b;
                        pcnt_in = pcnt_ff + 3'd1;
                        if (pcnt_in >= seq_need(pend_ff[0])) begin
                           if (ch) begin
                              pidx_in = 3'd0;
                              state_in = ST_TAIL;
                           end else begin
                              pcnt_in = 3'd0;
                              pos_in = pos_nx;
                           end
                        end
                     end else if (pcnt_ff != 3'd0) begin
                        pidx_in = 3'd0;
                        hold_end_in = 1'b0;
                        hold_in = b;
                        state_in = ST_REPLAY;
                     end else if (seq_need(b) != 3'd0) begin
                        pend_in[0] = b;
                        pcnt_in = 3'd1;
                     end else begin
                        if (ch) begin
                           dout = 1'b1; db = b;
                        end
                        pos_in = pos_nx;
                     end
                  end
                  default: begin
                     if (eoi || nl) begin
                        if (nl) begin
                           dout = 1'b1; db = NEWLINE;
                        end
                        line_clr = 1'b1;
                     end else begin
                        if (ch) begin
                           dout = 1'b1; db = b;
                        end
                        pos_in = pos_nx;
                     end
                  end
               endcase
            end
         end
         ST_TAIL: begin
            if (out_free) begin
               dout = 1'b1;
               db = pend_ff[pidx_ff[1:0]];
               dlast = (pidx_ff + 3'd1 == pcnt_ff);
               pidx_in = pidx_ff + 3'd1;
               if (dlast) begin
                  pcnt_in = 3'd0;
                  pos_in = pos_nx;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_REPLAY: begin
            if (can_go) begin
               if (pidx_ff < pcnt_ff) begin
                  if (ch) begin
                     put = 1'b1; pb = pend_ff[pidx_ff[1:0]];
                  end
                  pos_in = pos_nx;
                  pidx_in = pidx_ff + 3'd1;
               end else begin
                  pcnt_in = 3'd0;
                  state_in = ST_FLUSH;
                  if (hold_end_ff) begin
                     if (hold_nl_ff) begin
                        put = 1'b1; pb = NEWLINE;
                     end
                     line_clr = 1'b1;
                  end else if (seq_need(hold_ff) != 3'd0) begin
                     pend_in[0] = hold_ff;
                     pcnt_in = 3'd1;
                  end else begin
                     if (ch) begin
                        put = 1'b1; pb = hold_ff;
                     end
                     pos_in = pos_nx;
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (can_go) begin
               put = 1'b1;
               pb = ram_q;
               if (didx_ff < fcnt_ff) begin
                  ctl.rd = 1'b1;
                  ctl.raddr = didx_ff;
                  didx_in = didx_ff + 6'd1;
               end else begin
                  state_in = ST_CLOSE;
               end
            end
         end
         ST_CLOSE: begin
            if (can_go) begin
               if (hold_end_ff) begin
                  if (hold_nl_ff) begin
                     put = 1'b1; pb = NEWLINE;
                  end
                  line_clr = 1'b1;
               end else begin
                  pos_in = pos_nx;
                  if (ch_nx) begin
                     put = 1'b1; pb = delim_ff;
                  end
               end
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!stg_v_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rv_in = 1'b1;
               rd_in = stg_ff;
               rd_in.last_of_run = 1'b1;
               stg_v_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (dout) begin
         rv_in = 1'b1;
         rd_in.out_byte = db;
         rd_in.last_of_run = dlast;
         rd_in.field_truncated = trunc_now;
      end
      if (put) begin
         if (stg_v_ff) begin
            rv_in = 1'b1;
            rd_in = stg_ff;
         end
         stg_v_in = 1'b1;
         stg_in.out_byte = pb;
         stg_in.last_of_run = 1'b0;
         stg_in.field_truncated = trunc_now;
      end
      if (csr_write && csr_index == CSR_UNIT) begin
         line_clr = 1'b1;
         state_in = ST_IDLE;
      end
      if (line_clr) begin
         pos_in = POSITION_BITS'(1);
         pcnt_in = 3'd0;
         fcnt_in = 6'd0;
         dseen_in = 1'b0;
         wrote_in = 1'b0;
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff <= POSITION_BITS'(1);
         pcnt_ff <= 3'd0;
         pidx_ff <= 3'd0;
         fcnt_ff <= 6'd0;
         didx_ff <= 6'd0;
         dseen_ff <= 1'b0;
         wrote_ff <= 1'b0;
         ovf_ff <= 1'b0;
         rv_ff <= 1'b0;
         stg_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff <= pos_in;
         pcnt_ff <= pcnt_in;
         pidx_ff <= pidx_in;
         fcnt_ff <= fcnt_in;
         didx_ff <= didx_in;
         dseen_ff <= dseen_in;
         wrote_ff <= wrote_in;
         ovf_ff <= ovf_in;
         rv_ff <= rv_in;
         stg_v_ff <= stg_v_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      hold_ff <= hold_in;
      hold_nl_ff <= hold_nl_in;
      hold_end_ff <= hold_end_in;
      rd_ff <= rd_in;
      stg_ff <= stg_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_data = rd_ff;

   `LCC_ASSERT_IMP(a_stall_busy, clock, reset, state_ff != ST_IDLE, req_stall)
   `LCC_ASSERT_NEXT(a_hold_valid, clock, reset, rv_ff && rsp_stall, rv_ff)
   `LCC_ASSERT_NEXT(a_hold_data, clock, reset, rv_ff && rsp_stall, $stable(rd_ff))
   `LCC_ASSERT_IMP(a_idle_stage, clock, reset, state_ff == ST_IDLE, !stg_v_ff)
   `LCC_ASSERT_IMP(a_fcnt, clock, reset, 1'b1, fcnt_ff <= DEPTH6)
endmodule
